FILE: design/spca_pkg.sv
// shared types and constants for the server pool countdown allocator
package spca_pkg;

   // field widths fixed by the interface
   localparam int SRV_W   = 3;
   localparam int CUST_W  = 16;
   localparam int FIELD_W = 16;
   localparam int DTIME_W = 18;
   localparam int COUNT_W = 4;
   localparam int CSR_W   = 4;

   localparam logic [CSR_W-1:0] CSR_RESET = 4'd1;

   // request operation codes
   localparam logic OP_ASSIGN = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_STATUS
   } state_type;

   typedef struct packed {
      logic               free_found;
      logic [SRV_W-1:0]   first_free_server;
      logic [COUNT_W-1:0] busy_count;
   } status_type;

endpackage

FILE: design/spca_req_if.sv
// request channel: valid/ready handshake with the assign or tick payload
interface spca_req_if
   import spca_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [SRV_W-1:0]   server_index;
   logic [CUST_W-1:0]  customer_number;
   logic [FIELD_W-1:0] arrival_time;
   logic [FIELD_W-1:0] waiting_time;
   logic [FIELD_W-1:0] transaction_time;
   logic [FIELD_W-1:0] service_time;

   modport source (
      output valid, operation, server_index, customer_number, arrival_time,
             waiting_time, transaction_time, service_time,
      input  ready
   );
   modport sink (
      input  valid, operation, server_index, customer_number, arrival_time,
             waiting_time, transaction_time, service_time,
      output ready
   );
endinterface

FILE: design/spca_rsp_if.sv
// response channel: valid/ready handshake with departure and status payload
interface spca_rsp_if
   import spca_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               last;
   logic               departed;
   logic [SRV_W-1:0]   departing_server;
   logic [CUST_W-1:0]  departing_customer;
   logic [DTIME_W-1:0] departure_time;
   logic               free_found;
   logic [SRV_W-1:0]   first_free_server;
   logic [COUNT_W-1:0] busy_count;

   modport source (
      output valid, last, departed, departing_server, departing_customer,
             departure_time, free_found, first_free_server, busy_count,
      input  ready
   );
   modport sink (
      input  valid, last, departed, departing_server, departing_customer,
             departure_time, free_found, first_free_server, busy_count,
      output ready
   );
endinterface

FILE: design/spca_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
module spca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [AW-1:0]        rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: design/spca_status.sv
// status summary: lowest free server and busy count over the servers in use
module spca_status
   import spca_pkg::*;
#(
   parameter int MAX_SERVERS = 8,
   localparam int NW = $clog2(MAX_SERVERS + 1)
) (
   input  logic [MAX_SERVERS-1:0] busy,
   input  logic [NW-1:0]          n_active,
   output status_type             status
);
   logic               found;
   logic [SRV_W-1:0]   first;
   logic [NW-1:0]      count;

   always_comb begin
      found = 1'b0;
      first = '0;
      count = '0;
      // descending walk so the lowest free server wins
      for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
         if (i < n_active) begin
            if (busy[i]) begin
               count = count + NW'(1);
            end else begin
               found = 1'b1;
               first = SRV_W'(i);
            end
         end
      end
   end

   assign status.free_found        = found;
   assign status.first_free_server = first;
   assign status.busy_count        = COUNT_W'(count);
endmodule

FILE: design/server_pool_countdown_allocator_unit.sv
// top level of the server pool countdown allocator
//
// a bank of servers, each with a busy flag (flip-flops, cleared by reset) and a
// record held in one ram word: remaining service count, customer number,
// arrival, waiting and transaction time. an assign request writes the record
// of the named server and marks it busy; an assign to a server at or beyond
// servers_in_use is dropped. a tick request walks the servers in use in
// ascending order, reads each busy server's record, decrements its count and
// writes it back, or frees it and sends a departure response (departure time
// is arrival plus waiting plus transaction) when the count runs out. every
// request ends with one status response, marked last, carrying the lowest
// free server and the busy count. a tick reads each busy server's record on
// the single read port and checks it before it moves on; idle servers are
// skipped. the output register lets the next request in while the final
// status still waits to be taken; a full output register stalls the walk.
// the record ram needs no clearing pass after reset, as a record is only read
// behind a set busy flag. servers_in_use is to be written through csr_wr_en
// and csr_wr_data only while idle; the block itself does not enforce this.
// values above MAX_SERVERS act as MAX_SERVERS.
module server_pool_countdown_allocator_unit
   import spca_pkg::*;
#(
   parameter int MAX_SERVERS = 8,
   parameter int TIME_BITS   = 16
) (
   input  logic             clock,
   input  logic             reset,
   spca_req_if.sink         req_chan,
   spca_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);
   localparam int NW     = $clog2(MAX_SERVERS + 1);
   localparam int AW     = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int WORD_W = 4 * TIME_BITS + CUST_W;
   // record word layout, transaction time in the low bits
   localparam int WAIT_LO = TIME_BITS;
   localparam int ARR_LO  = 2 * TIME_BITS;
   localparam int CUST_LO = 3 * TIME_BITS;
   localparam int REM_LO  = 3 * TIME_BITS + CUST_W;

   // registers
   state_type              state_ff, state_in;
   logic [NW-1:0]          idx_ff, idx_in;
   logic [MAX_SERVERS-1:0] busy_ff, busy_in;
   logic [CSR_W-1:0]       siu_ff, siu_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_departed_ff, rsp_departed_in;
   logic [SRV_W-1:0]       rsp_server_ff, rsp_server_in;
   logic [CUST_W-1:0]      rsp_customer_ff, rsp_customer_in;
   logic [DTIME_W-1:0]     rsp_dtime_ff, rsp_dtime_in;
   status_type             rsp_status_ff, rsp_status_in;

   // control
   logic                   req_accept;
   logic                   assign_hit;
   logic                   out_free;
   logic [NW-1:0]          n_active;
   logic                   idx_busy;
   logic                   count_done;
   logic                   emit_dep;
   logic                   emit_status;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [WORD_W-1:0]      mem_wdata;
   logic [WORD_W-1:0]      mem_rdata;
   logic [TIME_BITS-1:0]   rd_rem;
   logic [TIME_BITS+1:0]   rd_dtime;
   status_type             status_now;

   // clamp servers in use to the bank size
   assign n_active = (siu_ff > MAX_SERVERS) ? NW'(MAX_SERVERS) : NW'(siu_ff);

   assign req_accept = req_chan.valid && req_chan.ready;
   assign assign_hit = (req_chan.operation == OP_ASSIGN) &&
                       (req_chan.server_index < n_active);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign idx_busy   = (idx_ff < n_active) && busy_ff[idx_ff[AW-1:0]];

   // fields of the record read for the server under check
   assign rd_rem     = mem_rdata[REM_LO +: TIME_BITS];
   assign count_done = (rd_rem <= TIME_BITS'(1));
   assign rd_dtime   = (TIME_BITS+2)'(mem_rdata[ARR_LO +: TIME_BITS])
                     + (TIME_BITS+2)'(mem_rdata[WAIT_LO +: TIME_BITS])
                     + (TIME_BITS+2)'(mem_rdata[TIME_BITS-1:0]);

   spca_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_SERVERS)
   ) u_record_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (mem_rdata)
   );

   spca_status #(
      .MAX_SERVERS (MAX_SERVERS)
   ) u_status (
      .busy     (busy_ff),
      .n_active (n_active),
      .status   (status_now)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_chan.operation == OP_TICK) ? ST_SCAN : ST_STATUS;
            end
         end
         ST_SCAN: begin
            if (idx_ff >= n_active) begin
               state_in = ST_STATUS;
            end else if (idx_busy) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // a finished server holds here until the output register frees
            if (!count_done || out_free) begin
               state_in = ST_SCAN;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      idx_in         = idx_ff;
      busy_in        = busy_ff;
      mem_we         = 1'b0;
      mem_waddr      = idx_ff[AW-1:0];
      mem_wdata      = {rd_rem - TIME_BITS'(1), mem_rdata[REM_LO-1:0]};
      emit_dep       = 1'b0;
      emit_status    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            idx_in         = '0;
            mem_waddr      = AW'(req_chan.server_index);
            mem_wdata      = {TIME_BITS'(req_chan.service_time),
                              req_chan.customer_number,
                              TIME_BITS'(req_chan.arrival_time),
                              TIME_BITS'(req_chan.waiting_time),
                              TIME_BITS'(req_chan.transaction_time)};
            if (req_accept && assign_hit) begin
               mem_we                                 = 1'b1;
               busy_in[AW'(req_chan.server_index)]    = 1'b1;
            end
         end
         ST_SCAN: begin
            // idle servers are skipped, busy ones get their record read
            if ((idx_ff < n_active) && !idx_busy) begin
               idx_in = idx_ff + NW'(1);
            end
         end
         ST_CHECK: begin
            if (count_done) begin
               if (out_free) begin
                  emit_dep                   = 1'b1;
                  busy_in[idx_ff[AW-1:0]]    = 1'b0;
                  idx_in                     = idx_ff + NW'(1);
               end
            end else begin
               mem_we = 1'b1;
               idx_in = idx_ff + NW'(1);
            end
         end
         ST_STATUS: begin
            emit_status = out_free;
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
   end

   // output register loads
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_last_in     = rsp_last_ff;
      rsp_departed_in = rsp_departed_ff;
      rsp_server_in   = rsp_server_ff;
      rsp_customer_in = rsp_customer_ff;
      rsp_dtime_in    = rsp_dtime_ff;
      rsp_status_in   = rsp_status_ff;
      if (emit_dep) begin
         rsp_valid_in    = 1'b1;
         rsp_last_in     = 1'b0;
         rsp_departed_in = 1'b1;
         rsp_server_in   = SRV_W'(idx_ff);
         rsp_customer_in = mem_rdata[CUST_LO +: CUST_W];
         rsp_dtime_in    = DTIME_W'(rd_dtime);
         rsp_status_in   = '0;
      end else if (emit_status) begin
         rsp_valid_in    = 1'b1;
         rsp_last_in     = 1'b1;
         rsp_departed_in = 1'b0;
         rsp_server_in   = '0;
         rsp_customer_in = '0;
         rsp_dtime_in    = '0;
         rsp_status_in   = status_now;
      end
   end

   assign siu_in = csr_wr_en ? csr_wr_data : siu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         busy_ff      <= '0;
         siu_ff       <= CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         busy_ff      <= busy_in;
         siu_ff       <= siu_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_last_ff     <= rsp_last_in;
      rsp_departed_ff <= rsp_departed_in;
      rsp_server_ff   <= rsp_server_in;
      rsp_customer_ff <= rsp_customer_in;
      rsp_dtime_ff    <= rsp_dtime_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.last               = rsp_last_ff;
   assign rsp_chan.departed           = rsp_departed_ff;
   assign rsp_chan.departing_server   = rsp_server_ff;
   assign rsp_chan.departing_customer = rsp_customer_ff;
   assign rsp_chan.departure_time     = rsp_dtime_ff;
   assign rsp_chan.free_found         = rsp_status_ff.free_found;
   assign rsp_chan.first_free_server  = rsp_status_ff.first_free_server;
   assign rsp_chan.busy_count         = rsp_status_ff.busy_count;

   // a departure frees exactly one server
   a_dep_frees_one: assert property (@(posedge clock) disable iff (reset)
      emit_dep |=> ($countones(busy_ff) == $countones($past(busy_ff)) - 1))
      else $error("departure did not free exactly one server");

   // the record under check always belongs to a server in use
   a_check_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (idx_ff < n_active))
      else $error("record check outside the servers in use");

   // at most one server becomes busy per cycle
   a_busy_grows_by_one: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> ($countones(busy_ff) <= $countones($past(busy_ff)) + 1))
      else $error("more than one server became busy in a cycle");
endmodule

FILE: dv/pool_response_checker.sv
// checker for the server pool allocator: predicts departures and status, compares responses
`timescale 1ns / 100ps

module pool_response_checker
   import spca_pkg::*;
#(
   parameter int NUM_SERVERS = 8
) (
   input  logic             clock,
   input  logic             reset,
   spca_req_if              req_mon,
   spca_rsp_if              rsp_mon,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data,
   output int               mismatch_count,
   output int               outstanding
);

   typedef struct packed {
      logic               last;
      logic               departed;
      logic [SRV_W-1:0]   server;
      logic [CUST_W-1:0]  customer;
      logic [DTIME_W-1:0] dtime;
      logic               free_found;
      logic [SRV_W-1:0]   first_free;
      logic [COUNT_W-1:0] busy_count;
   } pool_rsp_type;

   pool_rsp_type       awaited_rsp_q[$];
   logic [CSR_W-1:0]   servers_in_use;
   logic               busy[NUM_SERVERS];
   logic [FIELD_W-1:0] countdown[NUM_SERVERS];
   logic [CUST_W-1:0]  customer[NUM_SERVERS];
   logic [FIELD_W-1:0] arrival[NUM_SERVERS];
   logic [FIELD_W-1:0] waited[NUM_SERVERS];
   logic [FIELD_W-1:0] transact[NUM_SERVERS];
   int                 errors = 0;

   // one request: update the pool copy, queue its departures then its status
   task automatic apply_request();
      int                 n;
      pool_rsp_type       r;
      logic               found;
      logic [SRV_W-1:0]   first_free;
      logic [COUNT_W-1:0] nbusy;
      n = (servers_in_use > NUM_SERVERS) ? NUM_SERVERS : int'(servers_in_use);
      if (req_mon.operation == OP_ASSIGN) begin
         if (int'(req_mon.server_index) < n) begin
            busy[req_mon.server_index]      = 1'b1;
            countdown[req_mon.server_index] = req_mon.service_time;
            customer[req_mon.server_index]  = req_mon.customer_number;
            arrival[req_mon.server_index]   = req_mon.arrival_time;
            waited[req_mon.server_index]    = req_mon.waiting_time;
            transact[req_mon.server_index]  = req_mon.transaction_time;
         end
      end else begin
         for (int i = 0; i < n; i++) begin
            if (busy[i]) begin
               if (countdown[i] <= 1) begin
                  r          = '0;
                  r.departed = 1'b1;
                  r.server   = SRV_W'(i);
                  r.customer = customer[i];
                  r.dtime    = DTIME_W'(arrival[i]) + DTIME_W'(waited[i])
                               + DTIME_W'(transact[i]);
                  awaited_rsp_q.push_back(r);
                  busy[i]      = 1'b0;
                  countdown[i] = '0;
               end else begin
                  countdown[i] = countdown[i] - 1'b1;
               end
            end
         end
      end
      found      = 1'b0;
      first_free = '0;
      nbusy      = '0;
      for (int i = 0; i < n; i++) begin
         if (busy[i]) begin
            nbusy = nbusy + 1'b1;
         end else if (!found) begin
            found      = 1'b1;
            first_free = SRV_W'(i);
         end
      end
      r            = '0;
      r.last       = 1'b1;
      r.free_found = found;
      r.first_free = first_free;
      r.busy_count = nbusy;
      awaited_rsp_q.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   task automatic check_response();
      pool_rsp_type w;
      if (awaited_rsp_q.size() == 0) begin
         $error("response with no request outstanding");
         errors++;
      end else begin
         w = awaited_rsp_q.pop_front();
         check_field("last", 32'(w.last), 32'(rsp_mon.last));
         check_field("departed", 32'(w.departed), 32'(rsp_mon.departed));
         check_field("departing_server", 32'(w.server), 32'(rsp_mon.departing_server));
         check_field("departing_customer", 32'(w.customer),
                     32'(rsp_mon.departing_customer));
         check_field("departure_time", 32'(w.dtime), 32'(rsp_mon.departure_time));
         check_field("free_found", 32'(w.free_found), 32'(rsp_mon.free_found));
         check_field("first_free_server", 32'(w.first_free),
                     32'(rsp_mon.first_free_server));
         check_field("busy_count", 32'(w.busy_count), 32'(rsp_mon.busy_count));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         servers_in_use = CSR_RESET;
         foreach (busy[i]) busy[i] = 1'b0;
         awaited_rsp_q.delete();
      end else begin
         if (csr_wr_en) servers_in_use = csr_wr_data;
         if (req_mon.valid && req_mon.ready) apply_request();
         if (rsp_mon.valid && rsp_mon.ready) check_response();
      end
      mismatch_count <= errors;
      outstanding    <= awaited_rsp_q.size();
   end

endmodule

FILE: dv/tb.sv
// testbench top for the server pool countdown allocator: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb
   import spca_pkg::*;
   ();

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   spca_req_if req_chan ();
   spca_rsp_if rsp_chan ();

   int mismatch_count;
   int outstanding;

   // idling odds in percent, changed between phases
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;

   // servers_in_use as last written, used to aim assigns inside the pool and to tell which requests count
   int cur_servers = 1;

   server_pool_countdown_allocator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pool_response_checker u_pool_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver side: ready redrawn every falling edge from the current stall odds
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // generous fixed limit, far above the slowest correct run
   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

   // one request: optional idle cycles, then hold valid until the handshake
   task automatic send_request(input logic op, input logic [SRV_W-1:0] idx,
                               input logic [CUST_W-1:0] cust,
                               input logic [FIELD_W-1:0] arr, input logic [FIELD_W-1:0] wtg,
                               input logic [FIELD_W-1:0] trn, input logic [FIELD_W-1:0] svc);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.operation        <= op;
      req_chan.server_index     <= idx;
      req_chan.customer_number  <= cust;
      req_chan.arrival_time     <= arr;
      req_chan.waiting_time     <= wtg;
      req_chan.transaction_time <= trn;
      req_chan.service_time     <= svc;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // stop sending and let every predicted response come back
   task automatic drain_pool();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // register write, only ever called with the pool drained
   task automatic write_servers_in_use(input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cur_servers = int'(value);
   endtask

   // random request; counts is low for an assign the block will drop
   task automatic random_request(output bit counts);
      logic               op;
      logic [SRV_W-1:0]   idx;
      logic [FIELD_W-1:0] svc;
      int                 n_eff;
      int                 pick;
      n_eff = (cur_servers > 8) ? 8 : cur_servers;
      op    = $urandom_range(1) ? OP_TICK : OP_ASSIGN;
      // mostly aim inside the pool, sometimes anywhere so that drops happen too
      if (n_eff != 0 && $urandom_range(3) != 0) idx = SRV_W'($urandom_range(n_eff - 1));
      else idx = SRV_W'($urandom_range(7));
      // short service times keep departures frequent; a few long ones park servers
      pick = $urandom_range(99);
      if (pick < 70) svc = FIELD_W'($urandom_range(4, 1));
      else if (pick < 90) svc = FIELD_W'($urandom_range(20, 5));
      else svc = FIELD_W'($urandom_range(65535, 1));
      counts = (op == OP_TICK) || (int'(idx) < n_eff);
      send_request(op, idx, CUST_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                   FIELD_W'($urandom), svc);
   endtask

   initial begin
      int unsigned      svc_plan[8] = '{1, 2, 65535, 1, 3, 1, 2, 1};
      logic [CSR_W-1:0] phase_servers[8] = '{4'd8, 4'd3, 4'd0, 4'd15,
                                             4'd1, 4'd8, 4'd5, 4'd12};
      int               counted;
      bit               counts;

      // every block input known from time zero
      reset                     = 1'b1;
      csr_wr_en                 = 1'b0;
      csr_wr_data               = '0;
      req_chan.valid            = 1'b0;
      req_chan.operation        = OP_ASSIGN;
      req_chan.server_index     = '0;
      req_chan.customer_number  = '0;
      req_chan.arrival_time     = '0;
      req_chan.waiting_time     = '0;
      req_chan.transaction_time = '0;
      req_chan.service_time     = 16'd1;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // --- directed part, no idling ---

      // one server after reset: full-width record departs with the largest sum
      send_request(OP_ASSIGN, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
      // assign beyond the servers in use is dropped, only status comes back
      send_request(OP_ASSIGN, 3'd5, 16'h1234, 16'd7, 16'd8, 16'd9, 16'd3);
      send_request(OP_TICK, 3'd0, '0, '0, '0, '0, 16'd1);
      // tick with nothing busy
      send_request(OP_TICK, 3'd7, '0, '0, '0, '0, 16'd1);
      drain_pool();

      // full pool: fill every server, overwrite one, then tick departures out
      write_servers_in_use(4'd8);
      for (int k = 0; k < 8; k++) begin
         send_request(OP_ASSIGN, SRV_W'(k), CUST_W'(k), FIELD_W'(k * 8191),
                      FIELD_W'(k * 1000), FIELD_W'(65535 - k * 9000),
                      FIELD_W'(svc_plan[k]));
      end
      // assign to a busy server replaces its customer with no departure
      send_request(OP_ASSIGN, 3'd3, 16'hBEEF, 16'd100, 16'd200, 16'd300, 16'd2);
      send_request(OP_TICK, 3'd0, '0, '0, '0, '0, 16'd1);
      send_request(OP_TICK, 3'd0, '0, '0, '0, '0, 16'd1);
      send_request(OP_TICK, 3'd0, '0, '0, '0, '0, 16'd1);
      drain_pool();

      // zero servers in use: assign dropped, tick leaves the parked server alone
      write_servers_in_use(4'd0);
      send_request(OP_ASSIGN, 3'd0, 16'h5555, 16'd1, 16'd1, 16'd1, 16'd1);
      send_request(OP_TICK, 3'd0, '0, '0, '0, '0, 16'd1);
      drain_pool();

      // value above the bank acts as a full pool
      write_servers_in_use(4'd15);
      send_request(OP_TICK, 3'd0, '0, '0, '0, '0, 16'd1);
      send_request(OP_ASSIGN, 3'd7, 16'hA5A5, 16'h8000, 16'h7FFF, 16'h0001, 16'd1);
      send_request(OP_ASSIGN, 3'd2, 16'h0F0F, 16'h0000, 16'hFFFF, 16'h1234, 16'd1);
      send_request(OP_TICK, 3'd0, '0, '0, '0, '0, 16'd1);
      drain_pool();

      // --- random phases: new pool size and idling mix each time ---
      // every phase ends in a full drain, so the sender waits out all responses
      for (int p = 0; p < 8; p++) begin
         write_servers_in_use(phase_servers[p]);
         unique case (p % 4)
            0: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 0;
            end
            1: begin
               tx_idle_pct  = 77;
               rx_stall_pct = 0;
            end
            2: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 77;
            end
            default: begin
               tx_idle_pct  = 6;
               rx_stall_pct = 6;
            end
         endcase
         counted = 0;
         while (counted < 50) begin
            random_request(counts);
            if (counts) counted++;
         end
         drain_pool();
      end

      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      repeat (20) @(negedge clock);

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/spca_pkg.sv
design/spca_req_if.sv
design/spca_rsp_if.sv
design/spca_ram.sv
design/spca_status.sv
design/server_pool_countdown_allocator_unit.sv
dv/pool_response_checker.sv
dv/tb.sv
